// ----- hdl/keyed_3bit_symbol_packer_defines.svh -----
// Assertion helpers for the symbol packer.
// Each check is sampled on clk and disabled while arst_n is low.
`ifndef KEYED_3BIT_SYMBOL_PACKER_DEFINES_SVH
`define KEYED_3BIT_SYMBOL_PACKER_DEFINES_SVH

// The condition holds at every edge.
`define KSP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("packer check failed");

// The trigger implies the condition at the next edge.
`define KSP_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("packer check failed");

`endif

// ----- hdl/ksp_pkg.sv -----
`timescale 1ns / 1ps

package ksp_pkg;

	localparam int unsigned KEY_ENTRIES = 7;
	localparam int unsigned CODE_W      = 3;
	localparam int unsigned SYM_W       = 8;
	localparam int unsigned KEY_W       = KEY_ENTRIES * SYM_W;
	localparam int unsigned PEND_W      = 7;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned APB_AW      = 4;
	localparam int unsigned APB_DW      = 64;

	localparam logic [CODE_W-1:0] TERM_CODE = 3'd7;

	// register index decoded from paddr[3]
	typedef enum logic {
		REG_KEY_TABLE = 1'b0,
		REG_NONE      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              missing;
	} lookup_t;

	typedef struct packed {
		logic [SYM_W-1:0] data;
		logic             last;
		logic             bad;
	} out_entry_t;

	// lowest matching entry wins; no match gives code 0 with missing set
	function automatic lookup_t lookup_code(input logic [SYM_W-1:0] ch,
			input logic [KEY_W-1:0] key);
		lookup_t r;
		r.code    = '0;
		r.missing = 1'b1;
		for (int k = KEY_ENTRIES - 1; k >= 0; k--) begin
			if (key[k*SYM_W +: SYM_W] == ch) begin
				r.code    = CODE_W'(k);
				r.missing = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/keyed_3bit_symbol_packer.sv -----
`timescale 1ns / 1ps
// Path: an accepted character is looked up and packed from the input register; its bytes
//   then go into the result queue, which drives the output.
// Throughput: one character per cycle while the output takes a byte per cycle; a character
//   that yields two bytes (final character) queues both at once for the output to drain.
// Reset (arst_n low, asynchronous): packer empty, error flag clear, key table zero,
//   input stage and result queue empty.

`include "keyed_3bit_symbol_packer_defines.svh"

module keyed_3bit_symbol_packer #(
	parameter int unsigned QDEPTH = ksp_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// character stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ksp_pkg::SYM_W-1:0]     s_axis_tdata,  // [7:0] symbol
	input  logic                          s_axis_tlast,  // final_symbol
	// packed byte stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ksp_pkg::SYM_W-1:0]     m_axis_tdata,  // [7:0] packed_byte
	output logic                          m_axis_tlast,  // last_byte
	output logic                          m_axis_tuser,  // [0] bad_symbol
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ksp_pkg::APB_AW-1:0]    paddr,
	input  logic [ksp_pkg::APB_DW-1:0]    pwdata,
	output logic [ksp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import ksp_pkg::*;

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	// ---------------- configuration ----------------
	logic [KEY_W-1:0] key_q;
	reg_idx_t         reg_sel;

	assign reg_sel = reg_idx_t'(paddr[3]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_sel)
			REG_KEY_TABLE: prdata = APB_DW'(key_q);
			REG_NONE:      prdata = '0;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_KEY_TABLE) begin
			key_q <= pwdata[KEY_W-1:0];
		end
	end

	// ---------------- input stage ----------------
	logic             valid_s1;
	logic [SYM_W-1:0] symbol_s1;
	logic             final_s1;
	logic [CNT_W-1:0] qcount_q;
	logic             advance;

	// the stage moves on only when the queue is sure to hold two more bytes
	assign advance       = valid_s1 && (qcount_q <= CNT_W'(QDEPTH - 2));
	assign s_axis_tready = !valid_s1 || (qcount_q <= CNT_W'(QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			symbol_s1 <= s_axis_tdata;
			final_s1  <= s_axis_tlast;
		end
	end

	// ---------------- lookup and bit packing ----------------
	logic [PEND_W-1:0] pend_bits_q;
	logic [2:0]        pend_cnt_q;
	logic              err_q;

	lookup_t           lk;
	logic              bad;
	logic [9:0]        acc_base;
	logic [12:0]       acc;
	logic [3:0]        cnt;
	logic              full_byte;
	logic [2:0]        rem;
	logic [15:0]       aligned;
	logic [7:0]        keep_mask;
	logic              push0;
	logic              push1;
	out_entry_t        ent0;
	out_entry_t        ent1;

	always_comb begin
		lk        = lookup_code(symbol_s1, key_q);
		bad       = err_q | lk.missing;
		acc_base  = {pend_bits_q, lk.code};
		// terminator code follows the final character directly
		acc       = final_s1 ? {acc_base, TERM_CODE} : {3'b000, acc_base};
		cnt       = 4'({1'b0, pend_cnt_q}) + 4'd3 + (final_s1 ? 4'd3 : 4'd0);
		full_byte = (cnt >= 4'd8);
		rem       = full_byte ? 3'(cnt - 4'd8) : cnt[2:0];
		// left-justify the live bits; unused low bits come out as zero padding
		aligned   = 16'(acc) << (5'd16 - 5'(cnt));
		keep_mask = (8'd1 << rem) - 8'd1;
		push0     = full_byte || final_s1;
		push1     = full_byte && final_s1 && (rem != 3'd0);
		ent0.data = aligned[15:8];
		ent0.last = final_s1 && !push1;
		ent0.bad  = bad;
		ent1.data = aligned[7:0];
		ent1.last = 1'b1;
		ent1.bad  = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			err_q       <= 1'b0;
		end else if (advance) begin
			if (final_s1) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				err_q       <= 1'b0;
			end else begin
				pend_bits_q <= acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
				pend_cnt_q  <= rem;
				err_q       <= bad;
			end
		end
	end

	// ---------------- result queue ----------------
	out_entry_t       queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             pop;
	logic [1:0]       npush;

	assign pop   = m_axis_tvalid && m_axis_tready;
	assign npush = advance ? (2'(push0) + 2'(push1)) : 2'd0;

	always_ff @(posedge clk) begin
		if (advance && push0) begin
			queue_q[wr_ptr_q] <= ent0;
		end
		if (advance && push1) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= ent1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			qcount_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(npush);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			qcount_q <= qcount_q + CNT_W'(npush) - CNT_W'(pop);
		end
	end

	assign m_axis_tvalid = (qcount_q != '0);
	assign m_axis_tdata  = queue_q[rd_ptr_q].data;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;
	assign m_axis_tuser  = queue_q[rd_ptr_q].bad;

	// ---------------- checks ----------------
	`KSP_ASSERT(a_queue_bound, qcount_q <= CNT_W'(QDEPTH))
	`KSP_ASSERT(a_stall_has_item, s_axis_tready || valid_s1)
	`KSP_ASSERT(a_push_has_room, !advance || (qcount_q <= CNT_W'(QDEPTH - 2)))
	`KSP_ASSERT_NEXT(a_final_clears, advance && final_s1, pend_cnt_q == 3'd0 && !err_q)

endmodule

// ----- sim/ksp_packer_checker.sv -----
`timescale 1ns / 1ps

// Watches the character, packed-byte and register channels, predicts each
// packed byte from the accepted characters and compares in order.
module ksp_packer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [ksp_pkg::SYM_W-1:0]    s_axis_tdata,   // [7:0] symbol
	input  logic                         s_axis_tlast,   // final_symbol
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [ksp_pkg::SYM_W-1:0]    m_axis_tdata,   // [7:0] packed_byte
	input  logic                         m_axis_tlast,   // last_byte
	input  logic                         m_axis_tuser,   // [0] bad_symbol
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ksp_pkg::APB_AW-1:0]   paddr,
	input  logic [ksp_pkg::APB_DW-1:0]   pwdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           bytes_pending
);
	import ksp_pkg::*;

	logic [KEY_W-1:0]  key_copy;
	logic [PEND_W-1:0] held_bits;
	int unsigned       held_cnt;
	logic              msg_bad;
	out_entry_t        expected_bytes[$];
	out_entry_t        oldest;
	int unsigned       byte_no;

	initial begin
		fail_count    = 0;
		bytes_pending = 0;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < 50) begin
			$display("[%0t] packed byte %0d: %s", $time, byte_no, what);
		end
		fail_count++;
	endtask

	// packs one character into the expected byte stream
	task automatic pack_symbol(input logic [SYM_W-1:0] sym, input logic fin);
		logic [CODE_W-1:0] code;
		logic              found;
		logic [15:0]       acc;
		int unsigned       cnt;
		out_entry_t        e;
		code  = '0;
		found = 1'b0;
		for (int k = 0; k < KEY_ENTRIES; k++) begin
			if (!found && key_copy[k*SYM_W +: SYM_W] == sym) begin
				code  = CODE_W'(k);
				found = 1'b1;
			end
		end
		if (!found)
			msg_bad = 1'b1;
		acc = (16'(held_bits) << CODE_W) | 16'(code);
		cnt = held_cnt + CODE_W;
		if (fin) begin
			acc = (acc << CODE_W) | 16'(TERM_CODE);
			cnt += CODE_W;
		end
		while (cnt >= 8) begin
			e.data = 8'(acc >> (cnt - 8));
			e.last = fin && (cnt == 8);
			e.bad  = msg_bad;
			expected_bytes.push_back(e);
			cnt -= 8;
			acc &= (16'd1 << cnt) - 16'd1;
		end
		if (fin) begin
			if (cnt > 0) begin
				e.data = 8'(acc << (8 - cnt));
				e.last = 1'b1;
				e.bad  = msg_bad;
				expected_bytes.push_back(e);
			end
			held_bits = '0;
			held_cnt  = 0;
			msg_bad   = 1'b0;
		end else begin
			held_bits = acc[PEND_W-1:0];
			held_cnt  = cnt;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_copy  = '0;
			held_bits = '0;
			held_cnt  = 0;
			msg_bad   = 1'b0;
			byte_no   = 0;
			expected_bytes.delete();
		end else begin
			// bytes leaving come from earlier requests, so check them first
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h", m_axis_tdata));
				end else begin
					oldest = expected_bytes.pop_front();
					if (m_axis_tdata !== oldest.data)
						report_mismatch($sformatf("packed_byte %h, expected %h",
							m_axis_tdata, oldest.data));
					if (m_axis_tlast !== oldest.last)
						report_mismatch($sformatf("last_byte %b, expected %b",
							m_axis_tlast, oldest.last));
					if (m_axis_tuser !== oldest.bad)
						report_mismatch($sformatf("bad_symbol %b, expected %b",
							m_axis_tuser, oldest.bad));
				end
				byte_no++;
			end
			if (psel && penable && pwrite && pready &&
					reg_idx_t'(paddr[3]) == REG_KEY_TABLE)
				key_copy = pwdata[KEY_W-1:0];
			if (s_axis_tvalid && s_axis_tready)
				pack_symbol(s_axis_tdata, s_axis_tlast);
		end
		bytes_pending = expected_bytes.size();
	end

endmodule

// ----- sim/tb_keyed_3bit_symbol_packer.sv -----
`timescale 1ns / 1ps

module tb_keyed_3bit_symbol_packer;
	import ksp_pkg::*;

	localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any request
	localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int unsigned SETTLE       = 8;     // covers the input register + queue
	localparam int unsigned PHASE_ITEMS  = 100;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SYM_W-1:0]    s_axis_tdata = '0;   // [7:0] symbol
	logic                s_axis_tlast = 1'b0; // final_symbol
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SYM_W-1:0]    m_axis_tdata;        // [7:0] packed_byte
	logic                m_axis_tlast;        // last_byte
	logic                m_axis_tuser;        // [0] bad_symbol
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int                  fail_count;
	int                  bytes_pending;

	// idle controls, in percent
	int unsigned         src_idle_pct = 0;
	int unsigned         snk_stall_pct = 0;
	logic                hold_arm = 1'b0;
	int unsigned         hold_left = 0;
	int unsigned         quiet_cycles = 0;
	logic [KEY_W-1:0]    key_now = '0;   // key the stimulus draws characters from

	keyed_3bit_symbol_packer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	ksp_packer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.bytes_pending (bytes_pending)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Output side: random stalls per phase, plus a one-shot long hold-off that
	// lets the result queue fill while the sender keeps offering characters.
	always @(negedge clk) begin
		if (hold_arm) begin
			hold_left = HOLD_CYCLES;
			hold_arm  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Watchdog: ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("keyed_3bit_symbol_packer verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One character request; entered and left at a falling edge.
	task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic fin);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Waits until every predicted byte is out, then lets the pipe settle so a
	// character still inside that yields no byte cannot race a key write.
	task automatic wait_drained();
		while (bytes_pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// Setup-then-access register write; upper pwdata bits carry junk on purpose.
	task automatic reg_write(input reg_idx_t idx, input logic [KEY_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= {8'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_KEY_TABLE)
			key_now = value;
	endtask

	// Random messages: mostly characters present in the key, some strays that
	// set the error flag; lengths short, now and then long.
	task automatic send_messages(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		logic [SYM_W-1:0] sym;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(10, 1);
			for (int unsigned i = 0; i < len; i++) begin
				if ($urandom_range(99) < 85)
					sym = key_now[$urandom_range(KEY_ENTRIES - 1)*SYM_W +: SYM_W];
				else
					sym = SYM_W'($urandom_range(255));
				send_symbol(sym, i == len - 1);
				sent++;
			end
		end
	endtask

	function automatic logic [KEY_W-1:0] phase_key(input int unsigned p);
		logic [KEY_W-1:0] k;
		logic [SYM_W-1:0] pool [3];
		k = KEY_W'({$urandom, $urandom});
		case (p)
			1: begin
				k = '0;
			end
			2: begin
				k = '1;
			end
			3: begin
				// heavy duplicates: lowest code must win
				pool[0] = SYM_W'($urandom);
				pool[1] = SYM_W'($urandom);
				pool[2] = SYM_W'($urandom);
				for (int i = 0; i < KEY_ENTRIES; i++)
					k[i*SYM_W +: SYM_W] = pool[$urandom_range(2)];
			end
			default: begin
			end
		endcase
		return k;
	endfunction

	initial begin
		@(negedge clk);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// key at reset is all zero: 0x00 hits code 0, 0x80 is a stray
		send_symbol(8'h00, 1'b0);
		send_symbol(8'h80, 1'b1);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// zero byte at code 0, 0x41 duplicated at codes 1 and 3, 0xFF at code 4
		reg_write(REG_KEY_TABLE, 56'h7E_80_FF_41_42_41_00);

		// eight characters: terminator lands alone in a fresh byte; one stray
		send_symbol(8'h00, 1'b0);
		send_symbol(8'h41, 1'b0);
		send_symbol(8'h42, 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'h80, 1'b0);
		send_symbol(8'h7E, 1'b0);
		send_symbol(8'h55, 1'b0);
		send_symbol(8'h41, 1'b1);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// out-of-range register index: must leave the key alone
		reg_write(REG_NONE, '1);

		// one-character message; error flag must be clear again
		send_symbol(8'h42, 1'b1);
		// stray in the middle of a message
		send_symbol(8'h80, 1'b0);
		send_symbol(8'h00, 1'b0);
		send_symbol(8'h55, 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'h7E, 1'b1);
		s_axis_tvalid <= 1'b0;

		// --- random phases: no idling, sender idle, receiver stall, both ---
		for (int unsigned p = 0; p < 8; p++) begin
			wait_drained();
			reg_write(REG_KEY_TABLE, phase_key(p));
			src_idle_pct  = (p % 4 == 1) ? 77 : (p % 4 == 3) ? 13 : 0;
			snk_stall_pct = (p % 4 == 2) ? 77 : (p % 4 == 3) ? 13 : 0;
			if (p == 0) begin
				@(posedge clk);
				hold_arm = 1'b1;
				@(negedge clk);
			end
			send_messages(PHASE_ITEMS);
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		if (fail_count == 0 && bytes_pending == 0) begin
			$display("keyed_3bit_symbol_packer verification clean");
		end else begin
			$display("keyed_3bit_symbol_packer verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ksp_pkg.sv
hdl/keyed_3bit_symbol_packer.sv
sim/ksp_packer_checker.sv
sim/tb_keyed_3bit_symbol_packer.sv
